FILE: rtl/ncc_pkg.sv
package ncc_pkg;

    // Block configuration.
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LEN     = 1024;

    // Field widths of the stream payloads.
    localparam int FIELD_W  = 16;
    localparam int DOT_W    = 42;
    localparam int CORR_W   = 16;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 2 * FIELD_W;
    localparam int OUT_W    = ((DOT_W + CORR_W + 7) / 8) * 8;

    // Accumulator widths follow from the sample width and the run length.
    localparam int LEN_BITS = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int PROD_W   = 2 * SAMPLE_BITS;
    localparam int E_W      = 2 * SAMPLE_BITS - 1 + LEN_BITS;
    localparam int CROSS_W  = E_W + 1;

    // Back end: serial products, then a bit-by-bit search for the Q1.15 magnitude.
    localparam int Q_W      = CORR_W;
    localparam int Q_SHIFT  = 2 * (Q_W - 1);
    localparam int PP_W     = 2 * E_W;
    localparam int BIG_W    = PP_W + 2 * Q_W + 1;
    localparam int STEP_W   = $clog2(E_W);

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_LEN  = 2'd2;

    typedef struct packed {
        logic ready;
        logic load;
        logic mul_step;
        logic srch_init;
        logic srch_add;
        logic srch_test;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_acc;
        logic skip;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/ncc_ctrl.sv
module ncc_ctrl
    import ncc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_INIT  = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_TEST  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_cnt;
    logic [STEP_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_ACC: begin
                o_cmd.ready = 1'b1;
                if (i_sts.last_acc) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = i_sts.skip ? S_OUT : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(E_W - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.srch_init = 1'b1;
                n_cnt           = '0;
                n_state         = S_ADD;
            end
            S_ADD: begin
                o_cmd.srch_add = 1'b1;
                n_state        = S_TEST;
            end
            S_TEST: begin
                o_cmd.srch_test = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                n_state         = (r_cnt == STEP_W'(Q_W - 1)) ? S_OUT : S_ADD;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/ncc_dp.sv
module ncc_dp
    import ncc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             s_axis_tvalid,
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic [STAT_W-1:0] m_axis_tuser
);

    logic                      w_acc;
    logic signed [SAMPLE_BITS-1:0] w_a;
    logic signed [SAMPLE_BITS-1:0] w_b;

    // Front end: product stage, then accumulate stage.
    logic                      r_v1;
    logic                      r_in1;
    logic signed [PROD_W-1:0]  r_pab;
    logic signed [PROD_W-1:0]  r_paa;
    logic signed [PROD_W-1:0]  r_pbb;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_ovf;
    logic signed [CROSS_W-1:0] r_cross;
    logic [E_W-1:0]            r_ea;
    logic [E_W-1:0]            r_eb;

    logic [STAT_W-1:0]         w_stat;
    logic [CROSS_W-1:0]        w_abs;

    // Back end work registers.
    logic [STAT_W-1:0]         r_stat;
    logic                      r_neg;
    logic [DOT_W-1:0]          r_dot;
    logic [PP_W-1:0]           r_ma;
    logic [E_W-1:0]            r_mb;
    logic [PP_W-1:0]           r_pp;
    logic [PP_W-1:0]           r_xa;
    logic [E_W-1:0]            r_xb;
    logic [PP_W-1:0]           r_mm;
    logic [BIG_W-1:0]          r_s;
    logic [BIG_W-1:0]          r_u;
    logic [BIG_W-1:0]          r_p2k;
    logic [BIG_W-1:0]          r_rhs;
    logic [BIG_W-1:0]          r_tmp;
    logic [Q_W-1:0]            r_q;
    logic [BIG_W-1:0]          w_cand;
    logic                      w_take;
    logic [BIG_W-1:0]          w_u;

    // Output register.
    logic                      r_ovalid;
    logic [DOT_W-1:0]          r_odot;
    logic [CORR_W-1:0]         r_ocorr;
    logic [STAT_W-1:0]         r_ostat;
    logic [CORR_W-1:0]         w_corr;

    assign w_acc = s_axis_tvalid & i_cmd.ready;
    assign w_a   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_b   = s_axis_tdata[FIELD_W+SAMPLE_BITS-1:FIELD_W];

    assign o_sts.last_acc = w_acc & s_axis_tlast;
    assign o_sts.skip     = (w_stat != ST_OK);
    assign o_sts.out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        if (r_ovf) begin
            w_stat = ST_LEN;
        end else if (r_ea == '0 || r_eb == '0) begin
            w_stat = ST_ZERO;
        end else begin
            w_stat = ST_OK;
        end
    end

    assign w_abs = r_cross[CROSS_W-1] ? CROSS_W'(-r_cross) : CROSS_W'(r_cross);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_in1   <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_cross <= '0;
            r_ea    <= '0;
            r_eb    <= '0;
        end else if (i_cmd.load) begin
            r_v1    <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_cross <= '0;
            r_ea    <= '0;
            r_eb    <= '0;
        end else begin
            r_v1 <= w_acc;
            if (w_acc) begin
                r_in1 <= (r_cnt < CNT_W'(MAX_LEN));
                if (r_cnt < CNT_W'(MAX_LEN)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_v1) begin
                if (r_in1) begin
                    r_cross <= r_cross + CROSS_W'(r_pab);
                    r_ea    <= r_ea + {{(E_W - PROD_W){1'b0}}, r_paa};
                    r_eb    <= r_eb + {{(E_W - PROD_W){1'b0}}, r_pbb};
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pab <= w_a * w_b;
            r_paa <= w_a * w_a;
            r_pbb <= w_b * w_b;
        end
    end

    // One candidate bit per add step and test step: S tracks q^2*P, U tracks q*P*2^(k+1),
    // and r_p2k holds P*2^(2k), so each trial needs only shifts and adds.
    assign w_cand = r_tmp + r_p2k;
    assign w_take = (w_cand <= r_rhs);
    assign w_u    = w_take ? (r_u + (r_p2k << 1)) : r_u;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stat <= w_stat;
            r_neg  <= r_cross[CROSS_W-1];
            r_dot  <= DOT_W'(r_cross);
            r_ma   <= PP_W'(r_ea);
            r_mb   <= r_eb;
            r_pp   <= '0;
            r_xa   <= PP_W'(w_abs[E_W-1:0]);
            r_xb   <= w_abs[E_W-1:0];
            r_mm   <= '0;
        end
        if (i_cmd.mul_step) begin
            if (r_mb[0]) begin
                r_pp <= r_pp + r_ma;
            end
            if (r_xb[0]) begin
                r_mm <= r_mm + r_xa;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
            r_xa <= r_xa << 1;
            r_xb <= r_xb >> 1;
        end
        if (i_cmd.srch_init) begin
            r_s   <= '0;
            r_u   <= '0;
            r_q   <= '0;
            r_p2k <= BIG_W'(r_pp) << Q_SHIFT;
            r_rhs <= BIG_W'(r_mm) << Q_SHIFT;
        end
        if (i_cmd.srch_add) begin
            r_tmp <= r_s + r_u;
        end
        if (i_cmd.srch_test) begin
            if (w_take) begin
                r_s <= w_cand;
            end
            r_u   <= w_u >> 1;
            r_p2k <= r_p2k >> 2;
            r_q   <= {r_q[Q_W-2:0], w_take};
        end
    end

    // A magnitude of one saturates to the Q1.15 limits; -1.0 is representable.
    always_comb begin
        if (r_stat != ST_OK) begin
            w_corr = '0;
        end else if (r_neg) begin
            w_corr = r_q[Q_W-1] ? {1'b1, {(Q_W - 1){1'b0}}} : CORR_W'(-r_q);
        end else begin
            w_corr = r_q[Q_W-1] ? {1'b0, {(Q_W - 1){1'b1}}} : r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odot  <= r_dot;
            r_ocorr <= w_corr;
            r_ostat <= r_stat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(OUT_W - DOT_W - CORR_W){1'b0}}, r_ocorr, r_odot};
    assign m_axis_tuser  = r_ostat;

endmodule

FILE: rtl/normalized_correlation_core.sv
// Normalized cross-correlation core. Sample pairs stream in one per clock while
// the input is ready and feed running sums of a*b, a*a and b*b. The transfer
// marked with tlast closes the run: the input then stalls while the back end
// forms Ea*Eb and p*p with two bit-serial multipliers (one step per energy bit)
// and then finds the Q1.15 magnitude bit by bit by trial compare. If the run
// was too long or an energy is zero, the back end is skipped and the result is
// ready after only the drain and load states. A result waits in
// the output register while the next run already streams in; the result
// reports the raw dot product, the correlation truncated toward zero with
// +1.0 limited to 32767, and a status code (ok, zero energy, run too long).
module normalized_correlation_core
    import ncc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // sample_a, sample_b
    input  logic              s_axis_tlast,   // last_pair
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // dot_product, corr_q15, zero fill
    output logic [STAT_W-1:0] m_axis_tuser    // status
);

    t_cmd w_cmd;
    t_sts w_sts;

    ncc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ncc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    assign s_axis_tready = w_cmd.ready;

endmodule

FILE: dv/tb_normalized_correlation_core.sv
`timescale 1ns / 100ps

module tb_normalized_correlation_core;
    import ncc_pkg::*;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES  = 150;

    typedef struct {
        logic signed [DOT_W-1:0]  dot;
        logic signed [CORR_W-1:0] corr;
        logic [STAT_W-1:0]        status;
    } t_corr_result;

    typedef struct {
        logic signed [FIELD_W-1:0] a;
        logic signed [FIELD_W-1:0] b;
        bit                        last;
        int                        reps;
        bit                        typed;
        t_corr_result              res;
    } t_pair_row;

    typedef enum int {
        FL_WIDE,
        FL_SAME,
        FL_NEGATED,
        FL_TINY,
        FL_ONE_SILENT,
        FL_EXTREME,
        FL_NOISY
    } t_run_flavor;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;   // sample_a, sample_b
    logic              s_axis_tlast = 1'b0; // last_pair
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // dot_product, corr_q15, zero fill
    logic [STAT_W-1:0] m_axis_tuser;        // status

    // Running sums of the predictor, cleared whenever a run closes.
    logic signed [DOT_W-1:0] run_cross = '0;
    logic [E_W-1:0]          run_ea = '0;
    logic [E_W-1:0]          run_eb = '0;
    int                      run_len = 0;
    bit                      run_over = 1'b0;

    t_corr_result corr_expected[$];
    t_pair_row    dir_rows[$];

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  results_checked = 0;
    int  pairs_sent = 0;
    int  runs_closed = 0;
    bit  src_gaps = 1'b1;

    int  sink_left = 0;
    bit  sink_on = 1'b0;
    int  sink_pick;

    normalized_correlation_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Largest q with q^2 * ea * eb <= 2^30 * mag^2, searched one bit at a time.
    function automatic logic [16:0] q15_magnitude(input logic [DOT_W-1:0] mag,
                                                  input logic [E_W-1:0] ea,
                                                  input logic [E_W-1:0] eb);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] trial;
        logic [16:0]  q;
        rhs = 128'(mag);
        rhs = (rhs * rhs) << 30;
        q = '0;
        for (int k = 15; k >= 0; k--) begin
            trial = 128'(q | (17'd1 << k));
            lhs = trial * trial * 128'(ea) * 128'(eb);
            if (lhs <= rhs)
                q = q | (17'd1 << k);
        end
        return q;
    endfunction

    task automatic fold_pair(input logic signed [FIELD_W-1:0] a,
                             input logic signed [FIELD_W-1:0] b,
                             input bit last,
                             output bit closed,
                             output t_corr_result res);
        logic signed [DOT_W-1:0] wa;
        logic signed [DOT_W-1:0] wb;
        logic [DOT_W-1:0]        mag;
        logic [16:0]             q;
        bit                      neg;
        wa = a;
        wb = b;
        closed = 1'b0;
        res.dot = '0;
        res.corr = '0;
        res.status = ST_OK;
        if (run_len < MAX_LEN) begin
            run_cross = run_cross + wa * wb;
            run_ea = run_ea + E_W'(wa * wa);
            run_eb = run_eb + E_W'(wb * wb);
            run_len++;
        end else begin
            run_over = 1'b1;
        end
        if (last) begin
            closed = 1'b1;
            if (run_over) begin
                res.status = ST_LEN;
            end else if (run_ea == '0 || run_eb == '0) begin
                res.status = ST_ZERO;
            end else begin
                neg = run_cross[DOT_W-1];
                mag = neg ? -run_cross : run_cross;
                q = q15_magnitude(mag, run_ea, run_eb);
                if (q > 17'd32768)
                    q = 17'd32768;
                if (neg)
                    res.corr = CORR_W'(-q);
                else
                    res.corr = (q > 17'd32767) ? 16'sd32767 : CORR_W'(q);
            end
            res.dot = run_cross;
            run_cross = '0;
            run_ea = '0;
            run_eb = '0;
            run_len = 0;
            run_over = 1'b0;
        end
    endtask

    // Idle length: mostly none or short, now and then a long pause.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else if (pick < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_pair(input logic signed [FIELD_W-1:0] a,
                             input logic signed [FIELD_W-1:0] b,
                             input bit last,
                             input bit typed,
                             input t_corr_result typed_res);
        int           gap;
        bit           closed;
        t_corr_result pr;
        gap = src_gaps ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        pairs_sent++;
        fold_pair(a, b, last, closed, pr);
        if (closed) begin
            runs_closed++;
            if (typed)
                corr_expected.push_back(typed_res);
            else
                corr_expected.push_back(pr);
        end
    endtask

    task automatic add_row(input int a, input int b, input bit last, input int reps,
                           input bit typed, input longint dot, input int corr,
                           input logic [STAT_W-1:0] status);
        t_pair_row row;
        row.a = FIELD_W'(a);
        row.b = FIELD_W'(b);
        row.last = last;
        row.reps = reps;
        row.typed = typed;
        row.res.dot = DOT_W'(dot);
        row.res.corr = CORR_W'(corr);
        row.res.status = status;
        dir_rows.push_back(row);
    endtask

    // Output side stalls: short and long holds, with steady stretches in between.
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 50) begin
                sink_on = 1'b1;
                sink_left = $urandom_range(1, 8);
            end else if (sink_pick < 75) begin
                sink_on = 1'b0;
                sink_left = $urandom_range(1, 3);
            end else if (sink_pick < 85) begin
                sink_on = 1'b0;
                sink_left = $urandom_range(4, 12);
            end else if (sink_pick < 90) begin
                sink_on = 1'b0;
                sink_left = $urandom_range(20, 60);
            end else begin
                sink_on = 1'b1;
                sink_left = $urandom_range(50, 200);
            end
        end
        sink_left = sink_left - 1;
        m_axis_tready <= sink_on;
    end

    always @(posedge i_clk) begin
        t_corr_result want;
        logic signed [DOT_W-1:0]  got_dot;
        logic signed [CORR_W-1:0] got_corr;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_dot  = m_axis_tdata[DOT_W-1:0];
            got_corr = m_axis_tdata[DOT_W+CORR_W-1:DOT_W];
            if (corr_expected.size() == 0) begin
                $error("result transfer with nothing expected: dot_product %0d", got_dot);
                mismatch_count++;
            end else begin
                want = corr_expected.pop_front();
                results_checked++;
                if (got_dot !== want.dot) begin
                    $error("dot_product: expected %0d, actual %0d", want.dot, got_dot);
                    mismatch_count++;
                end
                if (got_corr !== want.corr) begin
                    $error("corr_q15: expected %0d, actual %0d", want.corr, got_corr);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_corr_result none;
        t_run_flavor  flavor;
        int           random_items;
        int           run_pairs;
        int           long_runs;
        bit           silent_a;
        logic signed [FIELD_W-1:0] a;
        logic signed [FIELD_W-1:0] b;

        none.dot = '0;
        none.corr = '0;
        none.status = ST_OK;
        random_items = 0;
        long_runs = 0;

        // First run after reset: nothing accumulated but one silent pair.
        add_row(0, 0, 1, 1, 1, 0, 0, ST_ZERO);
        add_row(32767, 32767, 1, 1, 1, 64'd1073676289, 32767, ST_OK);
        add_row(-32768, -32768, 1, 1, 1, 64'd1073741824, 32767, ST_OK);
        add_row(-32768, 32767, 1, 1, 1, -64'd1073709056, -32768, ST_OK);
        add_row(1, -1, 1, 1, 1, -1, -32768, ST_OK);
        // One sequence silent, the other not.
        add_row(0, 123, 0, 1, 0, 0, 0, ST_OK);
        add_row(0, -7, 1, 1, 1, 0, 0, ST_ZERO);
        add_row(-5, 0, 1, 1, 1, 0, 0, ST_ZERO);
        // Orthogonal pair of vectors.
        add_row(3, 4, 0, 1, 0, 0, 0, ST_OK);
        add_row(4, -3, 1, 1, 1, 0, 0, ST_OK);
        add_row(100, 50, 0, 1, 0, 0, 0, ST_OK);
        add_row(50, 100, 1, 1, 0, 0, 0, ST_OK);
        add_row(1000, 2000, 0, 1, 0, 0, 0, ST_OK);
        add_row(-300, 700, 0, 1, 0, 0, 0, ST_OK);
        add_row(-32768, 12345, 1, 1, 0, 0, 0, ST_OK);
        // A run of exactly the maximum length is still fine.
        add_row(2, -3, 0, MAX_LEN - 1, 0, 0, 0, ST_OK);
        add_row(2, -3, 1, 1, 1, -6 * MAX_LEN, -32768, ST_OK);
        // One pair too many: only the first MAX_LEN pairs count.
        add_row(1, 1, 0, MAX_LEN, 0, 0, 0, ST_OK);
        add_row(1, 1, 1, 1, 1, MAX_LEN, 0, ST_LEN);
        // The sums must start from zero after the overflowed run.
        add_row(7, 7, 1, 1, 1, 49, 32767, ST_OK);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++) begin
            for (int r = 0; r < dir_rows[i].reps; r++) begin
                send_pair(dir_rows[i].a, dir_rows[i].b,
                          dir_rows[i].last && (r == dir_rows[i].reps - 1),
                          dir_rows[i].typed, dir_rows[i].res);
            end
        end

        while (random_items < RANDOM_ITEMS) begin
            if (long_runs < 2 && $urandom_range(0, 49) == 0) begin
                run_pairs = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
                long_runs++;
            end else if ($urandom_range(0, 99) < 70) begin
                run_pairs = $urandom_range(1, 8);
            end else if ($urandom_range(0, 99) < 85) begin
                run_pairs = $urandom_range(9, 48);
            end else begin
                run_pairs = $urandom_range(49, 200);
            end
            flavor = t_run_flavor'($urandom_range(0, 6));
            silent_a = $urandom_range(0, 1);
            src_gaps = ($urandom_range(0, 3) != 0);
            for (int p = 0; p < run_pairs; p++) begin
                a = FIELD_W'($urandom());
                b = FIELD_W'($urandom());
                case (flavor)
                    FL_SAME: begin
                        b = a;
                    end
                    FL_NEGATED: begin
                        b = -a;
                    end
                    FL_TINY: begin
                        a = FIELD_W'($urandom_range(0, 16)) - 16'sd8;
                        b = FIELD_W'($urandom_range(0, 16)) - 16'sd8;
                    end
                    FL_ONE_SILENT: begin
                        if (silent_a)
                            a = '0;
                        else
                            b = '0;
                    end
                    FL_EXTREME: begin
                        case ($urandom_range(0, 4))
                            0: a = 16'sh8000;
                            1: a = 16'sh7fff;
                            2: a = -16'sd1;
                            3: a = '0;
                            default: a = 16'sd1;
                        endcase
                        if ($urandom_range(0, 1))
                            b = (a == 16'sh8000) ? 16'sh7fff : 16'sh8000;
                    end
                    FL_NOISY: begin
                        b = a + FIELD_W'($urandom_range(0, 64)) - 16'sd32;
                    end
                    default: begin
                    end
                endcase
                send_pair(a, b, p == run_pairs - 1, 1'b0, none);
            end
            random_items += run_pairs;
        end

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (corr_expected.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (corr_expected.size() != 0)
            $error("%0d expected results never arrived", corr_expected.size());

        $display("Streamed %0d sample pairs in %0d runs, among them zero-energy runs,",
                 pairs_sent, runs_closed);
        $display("runs at and past the length limit; %0d results checked under stalls.",
                 results_checked);
        if (mismatch_count == 0 && corr_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
